/* sv/cpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// shared constants, types and state codes of the cosine prototype classifier
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int DIM         = 1024;
    localparam int NUM_CLASSES = 16;
    localparam int ELEM_W      = 16;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = 2 * ACC_W;
    localparam int CNT_W       = 16;
    localparam int ID_W        = 4;
    localparam int IDX_W       = 10;
    localparam int FUNC_W      = 2;
    localparam int SCORE_W     = 16;
    localparam int ADDR_W      = $clog2(DIM);
    localparam int QUOT_W      = 32;
    localparam int ROOT_W      = 15;
    localparam int REM_W       = PROD_W + QUOT_W - 1;
    localparam int STEP_W      = $clog2(ACC_W);

    localparam logic [PROD_W-1:0]  EPS_RAW   = PROD_W'(17592186);
    localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(32768);
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_TRAIN    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    localparam logic KIND_TRAIN    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef struct packed {
        logic                     active;
        logic                     train;
        logic [ID_W-1:0]          cls;
        logic [IDX_W-1:0]         idx;
        logic signed [ELEM_W-1:0] value;
        logic [CNT_W-1:0]         cnt;
    } token_t;

    typedef struct packed {
        logic clear_all;
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] cnt;
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] pnorm;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAIN,
        ST_LOAD,
        ST_PICK,
        ST_WAIT,
        ST_SHIFT,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MULN,
        SC_MULD,
        SC_DIV,
        SC_SQRT,
        SC_DONE
    } score_state_t;

endpackage

/* sv/cpc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_if
// request and response channels of the classifier
// ----------------------------------------------------------------------------
interface cpc_in_if;
    import cpc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [ID_W-1:0]          train_class;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] value;

    modport source (output valid, func, train_class, elem_index, value, input ready);
    modport sink   (input valid, func, train_class, elem_index, value, output ready);
endinterface

interface cpc_out_if;
    import cpc_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ID_W-1:0]    best_class;
    logic               matched;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   set_count;

    modport source (output valid, kind, best_class, matched, score, set_count,
                    input ready);
    modport sink   (input valid, kind, best_class, matched, score, set_count,
                    output ready);
endinterface

/* sv/cpc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_cell
// one class: prototype memory, count, valid bit and accumulators
// ----------------------------------------------------------------------------
module cpc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [cpc_pkg::ID_W-1:0] cell_id,
    input  cpc_pkg::cell_ctrl_t   ctrl,
    input  cpc_pkg::token_t       tok_in,
    output cpc_pkg::token_t       tok_out,
    input  cpc_pkg::rec_t         rec_in,
    output cpc_pkg::rec_t         rec_out
);
    import cpc_pkg::*;

    logic signed [ELEM_W-1:0] mem [DIM];
    logic signed [ELEM_W-1:0] rd_reg;
    token_t                   tok_reg;
    logic                     valid_reg, valid_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ACC_W-1:0]         dot_reg, dot_next;
    logic [ACC_W-1:0]         pn_reg, pn_next;
    logic                     sh_valid_reg;
    logic [CNT_W-1:0]         sh_cnt_reg;

    logic                     hit, last, cls_act, wr_en;
    logic [ELEM_W:0]          sum;
    logic signed [ELEM_W-1:0] wr_data;
    logic signed [2*ELEM_W-1:0] qp, pp;
    logic [CNT_W-1:0]         new_cnt;
    logic [ACC_W-1:0]         dot_base, pn_base;

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[ADDR_W'(tok_in.idx)];
        if (wr_en)
        begin
            mem[ADDR_W'(tok_reg.idx)] <= wr_data;
        end
    end

    always_comb
    begin
        hit     = tok_reg.active && tok_reg.train && (tok_reg.cls == cell_id);
        cls_act = tok_reg.active && !tok_reg.train;
        last    = tok_reg.idx == IDX_W'(DIM - 1);
        sum     = {rd_reg[ELEM_W-1], rd_reg} + {tok_reg.value[ELEM_W-1], tok_reg.value};
        wr_data = (count_reg == '0) ? tok_reg.value : $signed(sum[ELEM_W:1]);
        wr_en   = hit;
        new_cnt = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
        qp      = tok_reg.value * rd_reg;
        pp      = rd_reg * rd_reg;
        dot_base = (tok_reg.idx == '0) ? '0 : dot_reg;
        pn_base  = (tok_reg.idx == '0) ? '0 : pn_reg;

        valid_next = valid_reg;
        count_next = count_reg;
        dot_next   = dot_reg;
        pn_next    = pn_reg;
        tok_out    = tok_reg;

        if (ctrl.clear_all)
        begin
            valid_next = 1'b0;
            count_next = '0;
            dot_next   = '0;
            pn_next    = '0;
        end
        else if (ctrl.shift)
        begin
            dot_next = rec_in.dot;
            pn_next  = rec_in.pnorm;
        end
        else if (hit && last)
        begin
            valid_next  = 1'b1;
            count_next  = new_cnt;
            tok_out.cnt = new_cnt;
        end
        else if (cls_act)
        begin
            if (valid_reg)
            begin
                dot_next = dot_base + ACC_W'(qp);
                pn_next  = pn_base + ACC_W'(pp);
            end
            else
            begin
                dot_next = '0;
                pn_next  = '0;
            end
        end

        rec_out.valid = sh_valid_reg;
        rec_out.cnt   = sh_cnt_reg;
        rec_out.dot   = dot_reg;
        rec_out.pnorm = pn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= '0;
            valid_reg    <= 1'b0;
            count_reg    <= '0;
            dot_reg      <= '0;
            pn_reg       <= '0;
            sh_valid_reg <= 1'b0;
            sh_cnt_reg   <= '0;
        end
        else
        begin
            tok_reg   <= tok_in;
            valid_reg <= valid_next;
            count_reg <= count_next;
            dot_reg   <= dot_next;
            pn_reg    <= pn_next;
            if (ctrl.load)
            begin
                sh_valid_reg <= valid_reg;
                sh_cnt_reg   <= count_reg;
            end
            else if (ctrl.shift)
            begin
                sh_valid_reg <= rec_in.valid;
                sh_cnt_reg   <= rec_in.cnt;
            end
        end
    end

endmodule

/* sv/cpc_score.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_score
// serial cosine score: shift-add products, restoring divide, bitwise root
// ----------------------------------------------------------------------------
module cpc_score (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cpc_pkg::ACC_W-1:0] dot,
    input  logic [cpc_pkg::ACC_W-1:0] qnorm,
    input  logic [cpc_pkg::ACC_W-1:0] pnorm,
    output logic                      busy,
    output logic                      done,
    output logic [cpc_pkg::SCORE_W-1:0] score
);
    import cpc_pkg::*;

    score_state_t        state_reg, state_next;
    logic [PROD_W-1:0]   a_reg, a_next;
    logic [ACC_W-1:0]    b_reg, b_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ACC_W-1:0]    d_reg, d_next;
    logic [PROD_W-1:0]   n_reg, n_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    dv_reg, dv_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic [ROOT_W-1:0]   s_reg, s_next;
    logic [ROOT_W-1:0]   m_reg, m_next;
    logic [SCORE_W-1:0]  score_reg, score_next;

    logic [PROD_W-1:0]   acc_sum;
    logic [ROOT_W-1:0]   t;
    logic [2*ROOT_W-1:0] tt;
    logic                ge;

    always_comb
    begin
        acc_sum = b_reg[0] ? acc_reg + a_reg : acc_reg;
        ge      = rem_reg >= dv_reg;
        t       = s_reg | m_reg;
        tt      = t * t;

        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        q_next     = q_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        score_next = score_reg;
        done       = 1'b0;

        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    d_next     = dot[ACC_W-1] ? (~dot) + 1'b1 : dot;
                    a_next     = PROD_W'(qnorm);
                    b_next     = pnorm;
                    acc_next   = '0;
                    step_next  = STEP_W'(ACC_W - 1);
                    state_next = SC_MULN;
                end
            end
            SC_MULN:
            begin
                acc_next  = acc_sum;
                a_next    = a_reg << 1;
                b_next    = b_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    n_next     = (acc_sum < EPS_RAW) ? EPS_RAW : acc_sum;
                    a_next     = PROD_W'(d_reg);
                    b_next     = d_reg;
                    acc_next   = '0;
                    step_next  = STEP_W'(ACC_W - 1);
                    state_next = SC_MULD;
                end
            end
            SC_MULD:
            begin
                acc_next  = acc_sum;
                a_next    = a_reg << 1;
                b_next    = b_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    rem_next   = REM_W'(acc_sum) << 30;
                    dv_next    = REM_W'(n_reg) << (QUOT_W - 1);
                    q_next     = '0;
                    step_next  = STEP_W'(QUOT_W - 1);
                    state_next = SC_DIV;
                end
            end
            SC_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dv_reg;
                end
                q_next    = {q_reg[QUOT_W-2:0], ge};
                dv_next   = dv_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    s_next     = '0;
                    m_next     = ROOT_W'(1) << (ROOT_W - 1);
                    state_next = SC_SQRT;
                end
            end
            SC_SQRT:
            begin
                if (q_reg[QUOT_W-1:QUOT_W-2] != 2'b00)
                begin
                    score_next = SCORE_MAX;
                    state_next = SC_DONE;
                end
                else
                begin
                    if (QUOT_W'(tt) <= q_reg)
                    begin
                        s_next = t;
                    end
                    m_next = m_reg >> 1;
                    if (m_reg[0])
                    begin
                        score_next = SCORE_W'((QUOT_W'(tt) <= q_reg) ? t : s_reg);
                        state_next = SC_DONE;
                    end
                end
            end
            SC_DONE:
            begin
                done       = 1'b1;
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        step_reg  <= step_next;
        d_reg     <= d_next;
        n_reg     <= n_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        q_reg     <= q_next;
        s_reg     <= s_next;
        m_reg     <= m_next;
        score_reg <= score_next;
    end

    assign busy  = state_reg != SC_IDLE;
    assign score = score_reg;

endmodule

/* sv/cosine_prototype_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_prototype_classifier
// nearest-prototype classifier by cosine similarity over a chain of class cells
// ----------------------------------------------------------------------------
// Each class lives in its own cell with a private prototype memory. A train or
// classify element travels down the cell chain one cell per cycle, and the
// next element is accepted only after it has passed the injection register
// and the whole chain; a clear command is taken without leaving the idle
// state. A finished training vector passes through ST_OUT to load the output
// register. After the last classify element the accumulators shift out of the
// chain one class per step into a shared serial score unit, which runs the two
// shift-add products, the divide and the root for each valid class and is
// skipped for an invalid class. A result waiting on a stalled response holds
// off new requests. No clearing pass follows reset.
module cosine_prototype_classifier (
    input logic        clk,
    input logic        rst_n,
    cpc_in_if.sink     req,
    cpc_out_if.source  rsp
);
    import cpc_pkg::*;

    top_state_t          state_reg, state_next;
    token_t              inject_reg, inject_next;
    logic [ACC_W-1:0]    qn_reg, qn_next;
    logic [ID_W-1:0]     k_reg, k_next;
    logic [SCORE_W-1:0]  best_reg, best_next;
    logic [ID_W-1:0]     best_id_reg, best_id_next;
    logic [CNT_W-1:0]    best_cnt_reg, best_cnt_next;
    logic                found_reg, found_next;
    logic                res_kind_reg, res_kind_next;
    logic [ID_W-1:0]     res_cls_reg, res_cls_next;
    logic                res_match_reg, res_match_next;
    logic [SCORE_W-1:0]  res_score_reg, res_score_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg;
    logic [ID_W-1:0]     out_cls_reg;
    logic                out_match_reg;
    logic [SCORE_W-1:0]  out_score_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic                out_load;

    cell_ctrl_t          ctrl;
    token_t              tok_w [NUM_CLASSES+1];
    rec_t                rec_w [NUM_CLASSES+1];
    token_t              tail;
    rec_t                rec;
    logic                sc_start, sc_busy, sc_done;
    logic [SCORE_W-1:0]  sc_score;
    logic signed [2*ELEM_W-1:0] qq;

    assign tok_w[0] = inject_reg;
    assign rec_w[0] = '0;
    assign tail     = tok_w[NUM_CLASSES];
    assign rec      = rec_w[NUM_CLASSES];

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_cell
        cpc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (ID_W'(g)),
            .ctrl    (ctrl),
            .tok_in  (tok_w[g]),
            .tok_out (tok_w[g+1]),
            .rec_in  (rec_w[g]),
            .rec_out (rec_w[g+1])
        );
    end

    cpc_score u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sc_start),
        .dot   (rec.dot),
        .qnorm (qn_reg),
        .pnorm (rec.pnorm),
        .busy  (sc_busy),
        .done  (sc_done),
        .score (sc_score)
    );

    assign req.ready = state_reg == ST_IDLE;

    always_comb
    begin
        qq = req.value * req.value;

        state_next     = state_reg;
        inject_next    = '0;
        qn_next        = qn_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        best_id_next   = best_id_reg;
        best_cnt_next  = best_cnt_reg;
        found_next     = found_reg;
        res_kind_next  = res_kind_reg;
        res_cls_next   = res_cls_reg;
        res_match_next = res_match_reg;
        res_score_next = res_score_reg;
        res_cnt_next   = res_cnt_reg;
        ctrl           = '0;
        sc_start       = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FUNC_CLEAR)
                    begin
                        ctrl.clear_all = 1'b1;
                        qn_next        = '0;
                    end
                    else if ((req.func == FUNC_TRAIN || req.func == FUNC_CLASSIFY) &&
                             ({1'b0, req.elem_index} < (IDX_W+1)'(DIM)) &&
                             (req.func != FUNC_TRAIN ||
                              {1'b0, req.train_class} < (ID_W+1)'(NUM_CLASSES)))
                    begin
                        inject_next.active = 1'b1;
                        inject_next.train  = req.func == FUNC_TRAIN;
                        inject_next.cls    = req.train_class;
                        inject_next.idx    = req.elem_index;
                        inject_next.value  = req.value;
                        inject_next.cnt    = '0;
                        if (req.func == FUNC_CLASSIFY)
                        begin
                            qn_next = ((req.elem_index == '0) ? '0 : qn_reg) + ACC_W'(qq);
                        end
                        state_next = ST_CHAIN;
                    end
                end
            end
            ST_CHAIN:
            begin
                if (tail.active)
                begin
                    if (tail.idx != IDX_W'(DIM - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (tail.train)
                    begin
                        res_kind_next  = KIND_TRAIN;
                        res_cls_next   = tail.cls;
                        res_match_next = 1'b1;
                        res_score_next = '0;
                        res_cnt_next   = tail.cnt;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                ctrl.load     = 1'b1;
                k_next        = ID_W'(NUM_CLASSES - 1);
                best_next     = '0;
                best_id_next  = '0;
                best_cnt_next = '0;
                found_next    = 1'b0;
                state_next    = ST_PICK;
            end
            ST_PICK:
            begin
                if (rec.valid)
                begin
                    sc_start   = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_WAIT:
            begin
                if (sc_done)
                begin
                    if (sc_score != '0 && sc_score >= best_reg)
                    begin
                        best_next     = sc_score;
                        best_id_next  = k_reg;
                        best_cnt_next = rec.cnt;
                        found_next    = 1'b1;
                    end
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                ctrl.shift = 1'b1;
                if (k_reg == '0)
                begin
                    res_kind_next  = KIND_CLASSIFY;
                    res_cls_next   = found_reg ? best_id_reg : '0;
                    res_match_next = found_reg;
                    res_score_next = found_reg ? best_reg : '0;
                    res_cnt_next   = found_reg ? best_cnt_reg : '0;
                    qn_next        = '0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = ST_PICK;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inject_reg    <= '0;
            qn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inject_reg    <= inject_next;
            qn_reg        <= qn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        best_reg      <= best_next;
        best_id_reg   <= best_id_next;
        best_cnt_reg  <= best_cnt_next;
        found_reg     <= found_next;
        res_kind_reg  <= res_kind_next;
        res_cls_reg   <= res_cls_next;
        res_match_reg <= res_match_next;
        res_score_reg <= res_score_next;
        res_cnt_reg   <= res_cnt_next;
        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_cls_reg   <= res_cls_reg;
            out_match_reg <= res_match_reg;
            out_score_reg <= res_score_reg;
            out_cnt_reg   <= res_cnt_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.best_class = out_cls_reg;
    assign rsp.matched    = out_match_reg;
    assign rsp.score      = out_score_reg;
    assign rsp.set_count  = out_cnt_reg;

    a_score_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sc_busy |-> (state_reg == ST_WAIT))
        else $error("score unit running outside wait state");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_score_reg <= SCORE_MAX))
        else $error("score above one");

    a_train_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_TRAIN) |->
            (out_match_reg && out_score_reg == '0))
        else $error("malformed training result");

endmodule
